// ===== sv/utf8d_pkg.sv =====
`default_nettype none

package utf8d_pkg;

	localparam int unsigned CpW = 21;

	localparam logic [CpW-1:0] MapOffset = 21'h00D800;

	typedef struct packed {
		logic [1:0]     bytes_pending;
		logic [CpW-1:0] partial_value;
		logic           discarding;
	} dec_state_t;

	typedef struct packed {
		logic           valid;
		logic [CpW-1:0] code_point;
		logic           is_error;
		logic           end_of_string;
	} dec_result_t;

	function automatic logic is_symbol_char(input logic [7:0] b);
		logic r;
		r = ((b >= 8'h61) && (b <= 8'h7A)) ||
			((b >= 8'h41) && (b <= 8'h5A)) ||
			((b >= 8'h30) && (b <= 8'h39)) ||
			(b == 8'h24) || (b == 8'h5F);
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== sv/utf8d_step.sv =====
`default_nettype none

module utf8d_step (
	input  wire logic                  map_en,
	input  wire logic [7:0]            in_byte,
	input  wire logic                  last,
	input  wire utf8d_pkg::dec_state_t cur,
	output utf8d_pkg::dec_state_t      nxt,
	output utf8d_pkg::dec_result_t     res
);
	import utf8d_pkg::*;

	logic           fail;
	logic [CpW-1:0] shifted;

	assign shifted = {cur.partial_value[CpW-7:0], in_byte[5:0]};

	always_comb begin
		nxt  = cur;
		res  = '0;
		fail = 1'b0;
		res.end_of_string = last;
		if (cur.discarding) begin
			if (last) begin
				nxt.discarding = 1'b0;
			end
		end else if (cur.bytes_pending == 2'd0) begin
			if (!in_byte[7]) begin
				res.valid = 1'b1;
				if (map_en && !is_symbol_char(in_byte)) begin
					res.code_point = {{(CpW-8){1'b0}}, in_byte} + MapOffset;
				end else begin
					res.code_point = {{(CpW-8){1'b0}}, in_byte};
				end
			end else if (in_byte[7:6] == 2'b10) begin
				fail = 1'b1;
			end else if (in_byte[7:5] == 3'b110) begin
				nxt.bytes_pending = 2'd1;
				nxt.partial_value = {{(CpW-5){1'b0}}, in_byte[4:0]};
				fail = last;
			end else if (in_byte[7:4] == 4'b1110) begin
				nxt.bytes_pending = 2'd2;
				nxt.partial_value = {{(CpW-4){1'b0}}, in_byte[3:0]};
				fail = last;
			end else if (in_byte[7:3] == 5'b11110) begin
				nxt.bytes_pending = 2'd3;
				nxt.partial_value = {{(CpW-3){1'b0}}, in_byte[2:0]};
				fail = last;
			end else begin
				fail = 1'b1;
			end
		end else if (in_byte[7:6] != 2'b10) begin
			fail = 1'b1;
		end else begin
			nxt.bytes_pending = cur.bytes_pending - 2'd1;
			if (cur.bytes_pending == 2'd1) begin
				res.valid = 1'b1;
				res.code_point = shifted;
				nxt.partial_value = '0;
			end else begin
				nxt.partial_value = shifted;
				fail = last;
			end
		end

		if (fail) begin
			nxt.bytes_pending     = 2'd0;
			nxt.partial_value     = '0;
			nxt.discarding        = !last;
			res.valid             = 1'b1;
			res.code_point        = '0;
			res.is_error          = 1'b1;
			res.end_of_string     = 1'b1;
		end
	end

endmodule

`default_nettype wire

// ===== sv/utf8_to_utf32_decoder.sv =====
`default_nettype none

// Channel   Direction  Handshake          Payload
// in        sink       in_valid/in_stall  in_byte, last_of_string
// out       source     out_valid/out_stall code_point, is_error, end_of_string
// config    sink       map_non_symbol_we  map_non_symbol
//
// Each request is taken into an input register and decoded from there into the result
// register once the output is free, so one byte per cycle is sustained while out_stall
// stays low. The decode state lives in a single register set.
// Reset clears the decode state, the mapping bit and both valid flags.
// While a result waits under out_stall, one more request is still taken and held.

module utf8_to_utf32_decoder (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     map_non_symbol_we,
	input  wire logic                     map_non_symbol,
	input  wire logic                     in_valid,
	output logic                          in_stall,
	input  wire logic [7:0]               in_byte,
	input  wire logic                     last_of_string,
	output logic                          out_valid,
	input  wire logic                     out_stall,
	output logic [utf8d_pkg::CpW-1:0]     code_point,
	output logic                          is_error,
	output logic                          end_of_string
);
	import utf8d_pkg::*;

	logic        map_q;
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        last_s1;
	logic        adv;
	dec_state_t  state_q;
	dec_state_t  state_nxt;
	dec_result_t res;

	assign adv      = valid_s1 && (!out_valid || !out_stall);
	assign in_stall = valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_q <= 1'b0;
		end else if (map_non_symbol_we) begin
			map_q <= map_non_symbol;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= in_byte;
			last_s1 <= last_of_string;
		end
	end

	utf8d_step u_step (
		.map_en  (map_q),
		.in_byte (byte_s1),
		.last    (last_s1),
		.cur     (state_q),
		.nxt     (state_nxt),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (adv) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv && res.valid) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && res.valid) begin
			code_point    <= res.code_point;
			is_error      <= res.is_error;
			end_of_string <= res.end_of_string;
		end
	end

endmodule

`default_nettype wire
